### hw/rtl/lcdseq_pkg.sv
// Shared types, bus codes and sizes for the character LCD command sequencer.
package lcdseq_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned NUM_W       = 32;
	localparam int unsigned DIGITS      = 10;
	localparam int unsigned BCD_W       = 4 * DIGITS;

	localparam logic [2:0] MODE_INIT    = 3'd0;
	localparam logic [2:0] MODE_COMMAND = 3'd1;
	localparam logic [2:0] MODE_DATA    = 3'd2;
	localparam logic [2:0] MODE_CLEAR   = 3'd3;
	localparam logic [2:0] MODE_CURSOR  = 3'd4;
	localparam logic [2:0] MODE_NUMBER  = 3'd5;
	localparam logic [2:0] MODE_GLYPH   = 3'd6;

	localparam logic [1:0] DTYPE_16X1  = 2'd0;
	localparam logic [1:0] DTYPE_RESET = 2'd1;

	localparam logic [7:0] FSET_ONE_LINE  = 8'h30;
	localparam logic [7:0] FSET_TWO_LINE  = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] CMD_SET_CGRAM  = 8'h40;
	localparam logic [7:0] ASCII_ZERO     = 8'h30;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  byte_value;
		logic [1:0]  row;
		logic [5:0]  column;
		logic [31:0] number_value;
		logic [2:0]  glyph_slot;
		logic [63:0] glyph_rows;
	} req_t;

	typedef struct packed {
		logic       register_select;
		logic [7:0] bus_byte;
		logic       last;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_SINGLE,
		OP_INIT,
		OP_NUMBER,
		OP_GLYPH
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        rs;
		logic [7:0]  byte0;
		logic [7:0]  cursor;
		logic [2:0]  slot;
		logic [31:0] number;
		logic [63:0] rows;
	} cmd_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] b;
		case (row)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

endpackage

### hw/rtl/lcdseq_front.sv
// Request decoder: accepts requests and turns them into queued sequencer commands.
module lcdseq_front (
	input  lcdseq_pkg::req_t req,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       display_type,
	input  logic             q_full,
	output logic             q_wr,
	output lcdseq_pkg::cmd_t q_data
);

	logic [7:0] cursor_cmd;

	assign full = q_full;
	assign cursor_cmd = lcdseq_pkg::row_base(req.row) + {2'b00, req.column}
		+ lcdseq_pkg::CMD_SET_DDRAM;
	assign q_wr = push && !q_full && (req.mode <= lcdseq_pkg::MODE_GLYPH);

	always_comb begin
		q_data        = '0;
		q_data.op     = lcdseq_pkg::OP_SINGLE;
		q_data.rs     = 1'b0;
		q_data.byte0  = req.byte_value;
		q_data.cursor = cursor_cmd;
		q_data.slot   = req.glyph_slot;
		q_data.number = req.number_value;
		q_data.rows   = req.glyph_rows;
		unique case (req.mode)
			lcdseq_pkg::MODE_INIT: begin
				q_data.op    = lcdseq_pkg::OP_INIT;
				q_data.byte0 = (display_type == lcdseq_pkg::DTYPE_16X1) ?
					lcdseq_pkg::FSET_ONE_LINE : lcdseq_pkg::FSET_TWO_LINE;
			end
			lcdseq_pkg::MODE_DATA: begin
				q_data.rs = 1'b1;
			end
			lcdseq_pkg::MODE_CLEAR: begin
				q_data.byte0 = lcdseq_pkg::CMD_CLEAR;
			end
			lcdseq_pkg::MODE_CURSOR: begin
				q_data.byte0 = cursor_cmd;
			end
			lcdseq_pkg::MODE_NUMBER: begin
				q_data.op = lcdseq_pkg::OP_NUMBER;
			end
			lcdseq_pkg::MODE_GLYPH: begin
				q_data.op    = lcdseq_pkg::OP_GLYPH;
				q_data.byte0 = lcdseq_pkg::CMD_SET_CGRAM | {2'b00, req.glyph_slot, 3'b000};
			end
			default: begin
				q_data.op = lcdseq_pkg::OP_SINGLE;
			end
		endcase
	end

endmodule

### hw/rtl/lcdseq_cmdq.sv
// Small command queue between the request decoder and the write sequencer.
module lcdseq_cmdq #(
	parameter int unsigned DEPTH = lcdseq_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  lcdseq_pkg::cmd_t wr_data,
	output logic             full,
	input  logic             rd,
	output lcdseq_pkg::cmd_t rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	lcdseq_pkg::cmd_t mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("Command queue holds more entries than its depth.");
	assert property (@(posedge clk) disable iff (!arst_n) !(wr && full) && !(rd && empty))
		else $error("Command queue written while full or read while empty.");

endmodule

### hw/rtl/lcdseq_back.sv
// Write sequencer: expands queued commands into LCD bus beats and converts numbers.
module lcdseq_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lcdseq_pkg::cmd_t q_data,
	input  logic             q_empty,
	output logic             q_rd,
	output lcdseq_pkg::rsp_t rsp,
	output logic             empty,
	input  logic             pop
);

	localparam int unsigned CONV_BITS   = 4;
	localparam int unsigned CONV_CYCLES = lcdseq_pkg::NUM_W / CONV_BITS;
	localparam int unsigned CONV_W      = $clog2(CONV_CYCLES);
	localparam logic [3:0] INIT_LAST_STEP   = 4'd2;
	localparam logic [3:0] GLYPH_ROW_LAST   = 4'd8;
	localparam logic [3:0] GLYPH_CURSOR_STEP = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_RUN
	} state_t;

	state_t                        st_q;
	lcdseq_pkg::cmd_t              cmd_q;
	logic [3:0]                    step_q;
	logic [CONV_W-1:0]             conv_q;
	logic [lcdseq_pkg::BCD_W-1:0]  bcd_q;
	logic [lcdseq_pkg::NUM_W-1:0]  bin_q;
	lcdseq_pkg::rsp_t              out_q;
	logic                          out_valid_q;

	logic [lcdseq_pkg::BCD_W-1:0]  bcd_nx;
	logic [lcdseq_pkg::NUM_W-1:0]  bin_nx;
	logic [3:0]                    lead_nx;
	lcdseq_pkg::rsp_t              beat;
	logic [2:0]                    row_idx;
	logic                          can_load;

	function automatic logic [lcdseq_pkg::BCD_W-1:0] bcd_adjust(
		input logic [lcdseq_pkg::BCD_W-1:0] v
	);
		logic [lcdseq_pkg::BCD_W-1:0] r;
		r = v;
		for (int i = 0; i < lcdseq_pkg::DIGITS; i++) begin
			if (r[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = r[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	assign q_rd     = (st_q == ST_IDLE) && !q_empty;
	assign can_load = !out_valid_q || pop;
	assign rsp      = out_q;
	assign empty    = !out_valid_q;
	assign row_idx  = 3'(step_q - 4'd1);

	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int k = 0; k < CONV_BITS; k++) begin
			bcd_nx = bcd_adjust(bcd_nx);
			{bcd_nx, bin_nx} = {bcd_nx[lcdseq_pkg::BCD_W-2:0], bin_nx, 1'b0};
		end
		lead_nx = '0;
		for (int i = 1; i < lcdseq_pkg::DIGITS; i++) begin
			if (bcd_nx[4*i +: 4] != 4'd0) begin
				lead_nx = 4'(i);
			end
		end
	end

	always_comb begin
		beat = '0;
		unique case (cmd_q.op)
			lcdseq_pkg::OP_SINGLE: begin
				beat.register_select = cmd_q.rs;
				beat.bus_byte        = cmd_q.byte0;
				beat.last            = 1'b1;
			end
			lcdseq_pkg::OP_INIT: begin
				case (step_q)
					4'd0:    beat.bus_byte = cmd_q.byte0;
					4'd1:    beat.bus_byte = lcdseq_pkg::CMD_DISPLAY_ON;
					default: beat.bus_byte = lcdseq_pkg::CMD_CLEAR;
				endcase
				beat.last = (step_q == INIT_LAST_STEP);
			end
			lcdseq_pkg::OP_NUMBER: begin
				beat.register_select = 1'b1;
				beat.bus_byte        = lcdseq_pkg::ASCII_ZERO + {4'b0000, bcd_q[4*step_q +: 4]};
				beat.last            = (step_q == 4'd0);
			end
			lcdseq_pkg::OP_GLYPH: begin
				if (step_q == 4'd0) begin
					beat.bus_byte = cmd_q.byte0;
				end else if (step_q <= GLYPH_ROW_LAST) begin
					beat.register_select = 1'b1;
					beat.bus_byte        = cmd_q.rows[8*row_idx +: 8];
				end else if (step_q == GLYPH_CURSOR_STEP) begin
					beat.bus_byte = cmd_q.cursor;
				end else begin
					beat.register_select = 1'b1;
					beat.bus_byte        = {5'b00000, cmd_q.slot};
					beat.last            = 1'b1;
				end
			end
			default: beat = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cmd_q       <= '0;
			step_q      <= '0;
			conv_q      <= '0;
			bcd_q       <= '0;
			bin_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_RUN && can_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q  <= q_data;
						step_q <= '0;
						if (q_data.op == lcdseq_pkg::OP_NUMBER) begin
							bin_q  <= q_data.number;
							bcd_q  <= '0;
							conv_q <= '0;
							st_q   <= ST_CONV;
						end else begin
							st_q <= ST_RUN;
						end
					end
				end
				ST_CONV: begin
					bin_q  <= bin_nx;
					bcd_q  <= bcd_nx;
					conv_q <= conv_q + 1'b1;
					if (conv_q == CONV_W'(CONV_CYCLES - 1)) begin
						step_q <= lead_nx;
						st_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (can_load) begin
						out_q <= beat;
						if (beat.last) begin
							st_q <= ST_IDLE;
						end else if (cmd_q.op == lcdseq_pkg::OP_NUMBER) begin
							step_q <= step_q - 1'b1;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && can_load && beat.last) |=> (st_q == ST_IDLE && out_valid_q))
		else $error("Final beat of a run did not return the sequencer to idle.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (step_q <= 4'd10))
		else $error("Sequencer step ran past the longest run.");

endmodule

### hw/rtl/char_lcd_command_sequencer.sv
// Top level of the character LCD command sequencer: display type register and wiring.
//
// Channel   Direction  Handshake               Beat
// req       in         push / full             one display request (req_t)
// rsp       out        pop / empty             one LCD bus write (rsp_t)
// cfg       in         cfg_we                  display type, 2 bits
//
// In the sequencer, a number is loaded, converted at 4 bits per cycle and then written as one
// bus write per digit.
// The decoder and the sequencer are parted by a command queue, so requests are taken while
// the sequencer works or waits on a full output register; a stalled pop holds the sequencer.
// Reset empties the queue and the output register and sets the display type to DTYPE_RESET, a two-line type.
module char_lcd_command_sequencer #(
	parameter int unsigned QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcdseq_pkg::req_t req,
	input  logic             push,
	output logic             full,
	output lcdseq_pkg::rsp_t rsp,
	output logic             empty,
	input  logic             pop,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_data
);

	logic [1:0]       display_type_q;
	logic             q_wr;
	logic             q_rd;
	logic             q_full;
	logic             q_empty;
	lcdseq_pkg::cmd_t q_wr_data;
	lcdseq_pkg::cmd_t q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_type_q <= lcdseq_pkg::DTYPE_RESET;
		end else if (cfg_we) begin
			display_type_q <= cfg_data;
		end
	end

	lcdseq_front u_front (
		.req          (req),
		.push         (push),
		.full         (full),
		.display_type (display_type_q),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_data       (q_wr_data)
	);

	lcdseq_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	lcdseq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rd_data),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.rsp     (rsp),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
